FILE: hdl/d2n_pkg.sv
package d2n_pkg;

    localparam int DEPTH_W  = 32;
    localparam int COL_W    = 12;
    localparam int ROW_W    = 16;
    localparam int CWID_W   = 13;
    localparam int NXY_W    = 16;
    localparam int NZ_W     = 15;
    localparam int TDATA_W  = 80;
    localparam int CFG_A_W  = 1;
    localparam int CFG_D_W  = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_A_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_HEIGHT = 1'b1;

    localparam logic [CWID_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [ROW_W-1:0]  HEIGHT_RST = 16'd480;

    // Job queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Arithmetic widths of the normalizer.
    localparam int DIFF_W = 34;
    localparam int MAG_W  = 30;
    localparam int SQ_W   = 60;
    localparam int SUM_W  = 62;
    localparam int ROOT_W = 31;
    localparam int Q_W    = 15;
    localparam int NUM_W  = 46;
    localparam int DEN_W  = 32;

    typedef struct packed {
        logic [CWID_W-1:0] width;
        logic [ROW_W-1:0]  height;
    } cfg_t;

    typedef struct packed {
        logic signed [DEPTH_W-1:0] left;
        logic signed [DEPTH_W-1:0] right;
        logic signed [DEPTH_W-1:0] top;
        logic signed [DEPTH_W-1:0] bottom;
        logic                      dx2;
        logic                      dy2;
        logic [COL_W-1:0]          col;
        logic [ROW_W-1:0]          row;
        logic                      last;
    } job_t;

    typedef struct packed {
        logic row_end;
    } front_stat_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
    } queue_stat_t;

endpackage

FILE: hdl/d2n_ram.sv
module d2n_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/d2n_front.sv
module d2n_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  d2n_pkg::cfg_t           cfg,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [31:0]             s_tdata,
    output logic                    job_valid,
    output d2n_pkg::job_t           job,
    input  logic                    q_full,
    output d2n_pkg::front_stat_t    stat
);

    localparam int CW = $clog2(MAX_WIDTH);

    typedef enum logic [2:0] {
        ST_PRIME0 = 3'b001,
        ST_PRIME1 = 3'b010,
        ST_RUN    = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] col_reg, col_next;
    logic [d2n_pkg::ROW_W-1:0] row_reg, row_next;
    logic [63:0] win_reg, win_next;
    logic signed [31:0] prev_a_reg, cur1_reg, cur2_reg;
    d2n_pkg::job_t slot_reg [0:2];
    logic [2:0] sv_reg, sv_next, sv_left;

    logic [CW:0] w_eff;
    logic [CW-1:0] w_last;
    logic [d2n_pkg::ROW_W-1:0] h_last;
    logic at_last_col, at_last_row, c_first, accept, push;
    logic ea, eb, ec;
    logic signed [31:0] cur, a_c, b_c, a_c1;
    logic [63:0] rd_data;
    logic re;
    logic [CW-1:0] raddr;
    d2n_pkg::job_t job_main, job_e1, job_e2;

    always_comb
    begin
        if (cfg.width == '0)
        begin
            w_eff = (CW+1)'(1);
        end
        else if (32'(cfg.width) > 32'(MAX_WIDTH))
        begin
            w_eff = (CW+1)'(MAX_WIDTH);
        end
        else
        begin
            w_eff = (CW+1)'(cfg.width);
        end
        w_last = CW'(w_eff - (CW+1)'(1));
        h_last = (cfg.height == '0) ? '0 : cfg.height - 16'd1;
    end

    assign at_last_col = (col_reg == w_last);
    assign at_last_row = (row_reg == h_last);
    assign c_first     = (col_reg == '0);
    assign cur  = $signed(s_tdata);
    // Window: entry of this column (upper half the row above, lower half two above).
    assign a_c  = $signed(win_reg[63:32]);
    assign b_c  = $signed(win_reg[31:0]);
    assign a_c1 = $signed(rd_data[63:32]);

    assign ea = (row_reg != '0);
    assign eb = at_last_row && !c_first;
    assign ec = at_last_row && at_last_col;

    always_comb
    begin
        job_main.left   = c_first ? a_c : prev_a_reg;
        job_main.right  = at_last_col ? a_c : a_c1;
        job_main.top    = (row_reg > 16'd1) ? b_c : a_c;
        job_main.bottom = cur;
        job_main.dx2    = !c_first && !at_last_col;
        job_main.dy2    = (row_reg > 16'd1);
        job_main.col    = d2n_pkg::COL_W'(col_reg);
        job_main.row    = row_reg - 16'd1;
        job_main.last   = ea && !eb && !ec;

        // Pixel to the left on the final row: its right neighbor just arrived.
        job_e1.left   = (col_reg > CW'(1)) ? cur2_reg : cur1_reg;
        job_e1.right  = cur;
        job_e1.top    = ea ? prev_a_reg : cur1_reg;
        job_e1.bottom = cur1_reg;
        job_e1.dx2    = (col_reg > CW'(1));
        job_e1.dy2    = 1'b0;
        job_e1.col    = d2n_pkg::COL_W'(col_reg - CW'(1));
        job_e1.row    = row_reg;
        job_e1.last   = eb && !ec;

        job_e2.left   = c_first ? cur : cur1_reg;
        job_e2.right  = cur;
        job_e2.top    = ea ? a_c : cur;
        job_e2.bottom = cur;
        job_e2.dx2    = 1'b0;
        job_e2.dy2    = 1'b0;
        job_e2.col    = d2n_pkg::COL_W'(col_reg);
        job_e2.row    = row_reg;
        job_e2.last   = ec;
    end

    always_comb
    begin
        if (sv_reg[0])
        begin
            job = slot_reg[0];
        end
        else if (sv_reg[1])
        begin
            job = slot_reg[1];
        end
        else
        begin
            job = slot_reg[2];
        end
        job_valid = |sv_reg;
        push      = job_valid && !q_full;
        sv_left   = push ? (sv_reg & (sv_reg - 3'd1)) : sv_reg;
        s_tready  = (state_reg == ST_RUN) && (sv_left == '0);
        accept    = s_tvalid && s_tready;
        sv_next   = accept ? {ec, eb, ea} : sv_left;
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        win_next   = win_reg;
        re         = 1'b0;
        raddr      = col_reg + CW'(2);
        case (state_reg)
            ST_PRIME0:
            begin
                re         = 1'b1;
                raddr      = col_reg;
                state_next = ST_PRIME1;
            end
            ST_PRIME1:
            begin
                re         = 1'b1;
                raddr      = col_reg + CW'(1);
                win_next   = rd_data;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (accept)
                begin
                    re       = 1'b1;
                    win_next = rd_data;
                    if (at_last_col)
                    begin
                        col_next   = '0;
                        row_next   = at_last_row ? '0 : row_reg + 16'd1;
                        state_next = ST_PRIME0;
                    end
                    else
                    begin
                        col_next = col_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_PRIME0;
            end
        endcase
    end

    d2n_ram #(
        .WIDTH (64),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata ({cur, a_c}),
        .re    (re),
        .raddr (raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_PRIME0;
            col_reg   <= '0;
            row_reg   <= '0;
            sv_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            sv_reg    <= sv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        if (accept)
        begin
            prev_a_reg  <= a_c;
            cur1_reg    <= cur;
            cur2_reg    <= cur1_reg;
            slot_reg[0] <= job_main;
            slot_reg[1] <= job_e1;
            slot_reg[2] <= job_e2;
        end
    end

    assign stat.row_end = accept && at_last_col;

endmodule

FILE: hdl/d2n_queue.sv
module d2n_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  d2n_pkg::job_t         din,
    input  logic                  pop,
    output logic                  valid,
    output d2n_pkg::job_t         dout,
    output d2n_pkg::queue_stat_t  stat
);

    d2n_pkg::job_t queue_reg [0:d2n_pkg::QUEUE_DEPTH-1];
    logic [d2n_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [d2n_pkg::QCNT_W-1:0] count_reg;
    logic do_push, do_pop;

    assign stat.full  = (count_reg == d2n_pkg::QCNT_W'(d2n_pkg::QUEUE_DEPTH));
    assign stat.count = count_reg;
    assign valid      = (count_reg != '0);
    assign dout       = queue_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + d2n_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + d2n_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + d2n_pkg::QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - d2n_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            queue_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: hdl/d2n_back.sv
module d2n_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  d2n_pkg::job_t                 q_job,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [d2n_pkg::TDATA_W-1:0]   m_tdata,
    output logic                          m_tlast
);

    localparam int ROOT_W = d2n_pkg::ROOT_W;
    localparam int Q_W    = d2n_pkg::Q_W;
    localparam int NUM_W  = d2n_pkg::NUM_W;
    localparam int MAG_W  = d2n_pkg::MAG_W;

    typedef struct packed {
        logic                      sx;
        logic                      sy;
        logic [MAG_W-1:0]          mx;
        logic [MAG_W-1:0]          my;
        logic [MAG_W-1:0]          mz;
        logic [d2n_pkg::COL_W-1:0] col;
        logic [d2n_pkg::ROW_W-1:0] row;
        logic                      last;
    } meta_t;

    logic en;

    // Stage A: differences scaled by the opposite step.
    logic a_vld_reg;
    logic signed [d2n_pkg::DIFF_W-1:0] a_x_reg, a_y_reg;
    logic [1:0] a_zsh_reg;
    logic [d2n_pkg::COL_W-1:0] a_col_reg;
    logic [d2n_pkg::ROW_W-1:0] a_row_reg;
    logic a_last_reg;
    logic signed [d2n_pkg::DIFF_W-1:0] dx_w, dy_w;

    // Stage B: magnitudes brought below 2^30 by a common shift.
    logic b_vld_reg;
    meta_t b_meta_reg;
    logic [d2n_pkg::DIFF_W-1:0] ux, uy, uz, uor;
    logic [2:0] sh;

    // Stage C: squares.
    logic c_vld_reg;
    meta_t c_meta_reg;
    logic [d2n_pkg::SQ_W-1:0] c_sqx_reg, c_sqy_reg, c_sqz_reg;

    // Square root, one result bit per stage; index 0 holds the sum.
    logic [d2n_pkg::SUM_W-1:0] sqrt_rem_reg [0:ROOT_W];
    logic [ROOT_W-1:0] sqrt_root_reg [0:ROOT_W];
    meta_t sqrt_meta_reg [0:ROOT_W];
    logic sqrt_vld_reg [0:ROOT_W];

    // Rounded division, one quotient bit per stage; index 0 holds the operands.
    logic [NUM_W-1:0] div_rem_reg [0:Q_W][0:2];
    logic [Q_W-1:0] div_q_reg [0:Q_W][0:2];
    logic [d2n_pkg::DEN_W-1:0] div_d_reg [0:Q_W];
    meta_t div_meta_reg [0:Q_W];
    logic div_vld_reg [0:Q_W];

    logic out_vld_reg;
    logic [d2n_pkg::NXY_W-1:0] out_nx_reg, out_ny_reg;
    logic [d2n_pkg::NZ_W-1:0] out_nz_reg;
    logic [d2n_pkg::COL_W-1:0] out_col_reg;
    logic [d2n_pkg::ROW_W-1:0] out_row_reg;
    logic out_last_reg;
    logic [d2n_pkg::NXY_W-1:0] qx_ext, qy_ext;

    assign en    = !out_vld_reg || m_tready;
    assign q_pop = en && q_valid;

    always_comb
    begin
        dx_w = $signed({{2{q_job.left[31]}}, q_job.left})
             - $signed({{2{q_job.right[31]}}, q_job.right});
        dy_w = $signed({{2{q_job.bottom[31]}}, q_job.bottom})
             - $signed({{2{q_job.top[31]}}, q_job.top});
        if (q_job.dy2)
        begin
            dx_w = dx_w <<< 1;
        end
        if (q_job.dx2)
        begin
            dy_w = dy_w <<< 1;
        end
    end

    always_comb
    begin
        ux  = a_x_reg[d2n_pkg::DIFF_W-1] ? (~a_x_reg + 34'd1) : a_x_reg;
        uy  = a_y_reg[d2n_pkg::DIFF_W-1] ? (~a_y_reg + 34'd1) : a_y_reg;
        uz  = 34'd65536 << a_zsh_reg;
        uor = ux | uy | uz;
        if (uor[33])
        begin
            sh = 3'd4;
        end
        else if (uor[32])
        begin
            sh = 3'd3;
        end
        else if (uor[31])
        begin
            sh = 3'd2;
        end
        else if (uor[30])
        begin
            sh = 3'd1;
        end
        else
        begin
            sh = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg       <= 1'b0;
            b_vld_reg       <= 1'b0;
            c_vld_reg       <= 1'b0;
            sqrt_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg       <= q_valid;
            b_vld_reg       <= a_vld_reg;
            c_vld_reg       <= b_vld_reg;
            sqrt_vld_reg[0] <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_x_reg    <= dx_w;
            a_y_reg    <= dy_w;
            a_zsh_reg  <= {1'b0, q_job.dx2} + {1'b0, q_job.dy2};
            a_col_reg  <= q_job.col;
            a_row_reg  <= q_job.row;
            a_last_reg <= q_job.last;

            b_meta_reg.sx   <= a_x_reg[d2n_pkg::DIFF_W-1];
            b_meta_reg.sy   <= a_y_reg[d2n_pkg::DIFF_W-1];
            b_meta_reg.mx   <= MAG_W'(ux >> sh);
            b_meta_reg.my   <= MAG_W'(uy >> sh);
            b_meta_reg.mz   <= MAG_W'(uz >> sh);
            b_meta_reg.col  <= a_col_reg;
            b_meta_reg.row  <= a_row_reg;
            b_meta_reg.last <= a_last_reg;

            c_meta_reg <= b_meta_reg;
            c_sqx_reg  <= b_meta_reg.mx * b_meta_reg.mx;
            c_sqy_reg  <= b_meta_reg.my * b_meta_reg.my;
            c_sqz_reg  <= b_meta_reg.mz * b_meta_reg.mz;

            sqrt_meta_reg[0] <= c_meta_reg;
            sqrt_root_reg[0] <= '0;
            sqrt_rem_reg[0]  <= d2n_pkg::SUM_W'(c_sqx_reg) + d2n_pkg::SUM_W'(c_sqy_reg)
                              + d2n_pkg::SUM_W'(c_sqz_reg);
        end
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        localparam int B = ROOT_W - 1 - k;
        logic [63:0] trial;
        logic fits;

        assign trial = (64'(sqrt_root_reg[k]) << (B + 1)) | (64'd1 << (2 * B));
        assign fits  = (64'(sqrt_rem_reg[k]) >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sqrt_vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                sqrt_vld_reg[k+1] <= sqrt_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sqrt_meta_reg[k+1] <= sqrt_meta_reg[k];
                if (fits)
                begin
                    sqrt_rem_reg[k+1]  <= d2n_pkg::SUM_W'(64'(sqrt_rem_reg[k]) - trial);
                    sqrt_root_reg[k+1] <= sqrt_root_reg[k] | (ROOT_W'(1) << B);
                end
                else
                begin
                    sqrt_rem_reg[k+1]  <= sqrt_rem_reg[k];
                    sqrt_root_reg[k+1] <= sqrt_root_reg[k];
                end
            end
        end
    end

    // Quotient is round(16384*m/L) = floor((32768*m + L) / (2*L)).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            div_vld_reg[0] <= sqrt_vld_reg[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_meta_reg[0] <= sqrt_meta_reg[ROOT_W];
            div_d_reg[0]    <= {sqrt_root_reg[ROOT_W], 1'b0};
            div_rem_reg[0][0] <= (NUM_W'(sqrt_meta_reg[ROOT_W].mx) << 15)
                               + NUM_W'(sqrt_root_reg[ROOT_W]);
            div_rem_reg[0][1] <= (NUM_W'(sqrt_meta_reg[ROOT_W].my) << 15)
                               + NUM_W'(sqrt_root_reg[ROOT_W]);
            div_rem_reg[0][2] <= (NUM_W'(sqrt_meta_reg[ROOT_W].mz) << 15)
                               + NUM_W'(sqrt_root_reg[ROOT_W]);
            div_q_reg[0][0] <= '0;
            div_q_reg[0][1] <= '0;
            div_q_reg[0][2] <= '0;
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_div
        localparam int B = Q_W - 1 - k;
        logic [NUM_W-1:0] dsh;

        assign dsh = NUM_W'(div_d_reg[k]) << B;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                div_vld_reg[k+1] <= div_vld_reg[k];
            end
        end

        for (genvar j = 0; j < 3; j++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (div_rem_reg[k][j] >= dsh)
                    begin
                        div_rem_reg[k+1][j] <= div_rem_reg[k][j] - dsh;
                        div_q_reg[k+1][j]   <= div_q_reg[k][j] | (Q_W'(1) << B);
                    end
                    else
                    begin
                        div_rem_reg[k+1][j] <= div_rem_reg[k][j];
                        div_q_reg[k+1][j]   <= div_q_reg[k][j];
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_meta_reg[k+1] <= div_meta_reg[k];
                div_d_reg[k+1]    <= div_d_reg[k];
            end
        end
    end

    assign qx_ext = {1'b0, div_q_reg[Q_W][0]};
    assign qy_ext = {1'b0, div_q_reg[Q_W][1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= div_vld_reg[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_nx_reg   <= div_meta_reg[Q_W].sx ? (~qx_ext + 16'd1) : qx_ext;
            out_ny_reg   <= div_meta_reg[Q_W].sy ? (~qy_ext + 16'd1) : qy_ext;
            out_nz_reg   <= div_q_reg[Q_W][2];
            out_col_reg  <= div_meta_reg[Q_W].col;
            out_row_reg  <= div_meta_reg[Q_W].row;
            out_last_reg <= div_meta_reg[Q_W].last;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b0, out_row_reg, out_col_reg, out_nz_reg, out_ny_reg, out_nx_reg};

endmodule

FILE: hdl/depth_to_normal_map_core.sv
// Depth-to-normal-map core.
// The s_ channel takes one depth sample per word (signed Q16.16) in raster
// order. The m_ channel returns one unit normal per word (signed Q1.14) with
// its pixel column and row; tlast marks the final normal caused by an input.
// Width and height are set through the write port; the user must do so
// between frames, as the block does not enforce it. Off the final row one
// sample is taken per clock while the job queue has room. After each row's
// last sample the input pauses while the line store read-ahead for the next
// row is loaded. On the final row an input causes up to three normals, and
// the next input is held until the front has queued them all, at one per
// clock while the queue has room. Each normal passes the square root, which
// resolves one bit per stage over 31 stages, and the rounded division, one
// bit per stage over 15 stages. When the receiver stalls, the whole
// normalizer pipeline holds, the short job queue fills and the input then
// stalls in turn; no word is dropped. Reset clears the counters, the queue
// and all valid flags, and reloads the default 640 x 480 frame size; the line
// stores are not cleared, since no entry is used before it is written.
module depth_to_normal_map_core #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [31:0]                          s_tdata,  // depth_sample
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // normal_x, normal_y, normal_z, pixel_col, pixel_row, zero fill
    output logic [d2n_pkg::TDATA_W-1:0]          m_tdata,
    output logic                                 m_tlast,
    input  logic                                 cfg_we,
    input  logic [d2n_pkg::CFG_A_W-1:0]          cfg_addr,
    input  logic [d2n_pkg::CFG_D_W-1:0]          cfg_wdata
);

    logic [d2n_pkg::CWID_W-1:0] width_reg;
    logic [d2n_pkg::ROW_W-1:0]  height_reg;
    d2n_pkg::cfg_t              cfg;
    d2n_pkg::job_t              push_job, q_job;
    d2n_pkg::front_stat_t       front_stat;
    d2n_pkg::queue_stat_t       q_stat;
    logic                       push_valid, q_valid, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= d2n_pkg::WIDTH_RST;
            height_reg <= d2n_pkg::HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                d2n_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata[d2n_pkg::CWID_W-1:0];
                d2n_pkg::CFG_HEIGHT: height_reg <= cfg_wdata;
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;

    d2n_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .job_valid (push_valid),
        .job       (push_job),
        .q_full    (q_stat.full),
        .stat      (front_stat)
    );

    d2n_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push_valid),
        .din   (push_job),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (q_job),
        .stat  (q_stat)
    );

    d2n_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTH
    a_row_gap: assert property (@(posedge clk) disable iff (!rst_n)
        front_stat.row_end |=> !s_tready)
        else $error("input taken right after the end of a row");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= d2n_pkg::QCNT_W'(d2n_pkg::QUEUE_DEPTH))
        else $error("job queue count beyond its depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.count != '0)
        else $error("job popped from an empty queue");
`endif

endmodule

FILE: verif/depth_to_normal_map_core_tb.sv
`timescale 1ns / 1ps

module depth_to_normal_map_core_tb;

    localparam int MAXW        = 4096;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_WAIT  = 120;

    typedef struct {
        logic [d2n_pkg::NXY_W-1:0] nx;
        logic [d2n_pkg::NXY_W-1:0] ny;
        logic [d2n_pkg::NZ_W-1:0]  nz;
        logic [d2n_pkg::COL_W-1:0] col;
        logic [d2n_pkg::ROW_W-1:0] row;
        bit                        last;
    } normal_t;

    // Mirrors the block: two line stores, raster counters and frame size,
    // and holds the normals still owed by the block.
    class normal_scoreboard;
        int              line_two_up[MAXW];
        int              line_up[MAXW];
        int unsigned     cur_col;
        int unsigned     cur_row;
        int unsigned     frame_w;
        int unsigned     frame_h;
        normal_t         pending[$];
        int              errors;

        function void clear();
            foreach (line_two_up[i]) line_two_up[i] = 0;
            foreach (line_up[i]) line_up[i] = 0;
            cur_col = 0;
            cur_row = 0;
            frame_w = d2n_pkg::WIDTH_RST;
            frame_h = d2n_pkg::HEIGHT_RST;
            pending.delete();
            errors = 0;
        endfunction

        function void set_reg(logic [d2n_pkg::CFG_A_W-1:0] idx,
                              logic [d2n_pkg::CFG_D_W-1:0] val);
            if (idx == d2n_pkg::CFG_WIDTH)
                frame_w = val[d2n_pkg::CWID_W-1:0];
            else
                frame_h = val;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return res;
        endfunction

        function longint unsigned unit_scale(longint unsigned m, longint unsigned len);
            return (2 * m * 16384 + len) / (2 * len);
        endfunction

        function normal_t make_normal(longint left, longint right, longint top,
                                      longint bottom, longint dx, longint dy,
                                      int unsigned col, int unsigned row);
            longint          gx, gy;
            longint unsigned ux, uy, uz, len, mx, my;
            normal_t         n;
            gx = (left - right) * dy;
            gy = (bottom - top) * dx;
            ux = (gx < 0) ? -gx : gx;
            uy = (gy < 0) ? -gy : gy;
            uz = dx * dy * 65536;
            while (ux >= (64'd1 << 30) || uy >= (64'd1 << 30) || uz >= (64'd1 << 30))
            begin
                ux >>= 1;
                uy >>= 1;
                uz >>= 1;
            end
            len = int_sqrt(ux * ux + uy * uy + uz * uz);
            mx = unit_scale(ux, len);
            my = unit_scale(uy, len);
            n.nx = d2n_pkg::NXY_W'((gx < 0) ? -mx : mx);
            n.ny = d2n_pkg::NXY_W'((gy < 0) ? -my : my);
            n.nz = d2n_pkg::NZ_W'(unit_scale(uz, len));
            n.col = d2n_pkg::COL_W'(col);
            n.row = d2n_pkg::ROW_W'(row);
            n.last = 0;
            return n;
        endfunction

        // One accepted depth word: the normal above it is finished, and on
        // the last row also the pixel to its left and, at row end, itself.
        function void note_sample(logic [d2n_pkg::DEPTH_W-1:0] sample);
            int unsigned w, h, c, r;
            longint      cur, self_v, lf, rt, tp, ddx, ddy;
            normal_t     batch[$];
            normal_t     n;
            w = (frame_w == 0) ? 1 : (frame_w > MAXW ? MAXW : frame_w);
            h = (frame_h == 0) ? 1 : frame_h;
            c = (cur_col > w - 1) ? w - 1 : cur_col;
            r = (cur_row > h - 1) ? h - 1 : cur_row;
            cur = $signed(sample);
            if (r >= 1)
            begin
                self_v = line_up[c];
                lf = (c > 0) ? line_two_up[c-1] : self_v;
                rt = (c < w - 1) ? line_up[c+1] : self_v;
                tp = (r > 1) ? line_two_up[c] : self_v;
                ddx = (c > 0 && c < w - 1) ? 2 : 1;
                ddy = (r > 1) ? 2 : 1;
                batch.push_back(make_normal(lf, rt, tp, cur, ddx, ddy, c, r - 1));
            end
            line_two_up[c] = line_up[c];
            line_up[c] = sample;
            if (r == h - 1)
            begin
                if (c >= 1)
                begin
                    self_v = line_up[c-1];
                    lf = (c > 1) ? line_up[c-2] : self_v;
                    tp = (r > 0) ? line_two_up[c-1] : self_v;
                    ddx = (c > 1) ? 2 : 1;
                    batch.push_back(make_normal(lf, cur, tp, self_v, ddx, 1, c - 1, r));
                end
                if (c == w - 1)
                begin
                    lf = (c > 0) ? line_up[c-1] : cur;
                    tp = (r > 0) ? line_two_up[c] : cur;
                    batch.push_back(make_normal(lf, cur, tp, cur, 1, 1, c, r));
                end
            end
            if (batch.size() > 0) batch[batch.size()-1].last = 1;
            foreach (batch[i]) pending.push_back(batch[i]);
            if (c >= w - 1)
            begin
                cur_col = 0;
                cur_row = (r >= h - 1) ? 0 : r + 1;
            end
            else
            begin
                cur_col = c + 1;
                cur_row = r;
            end
        endfunction

        function void check_normal(logic [d2n_pkg::TDATA_W-1:0] word, logic tlast);
            normal_t e;
            if (pending.size() == 0)
            begin
                $error("normal word with nothing expected: %h", word);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (word[15:0] !== e.nx)
            begin
                $error("normal_x expected %h actual %h", e.nx, word[15:0]);
                errors++;
            end
            if (word[31:16] !== e.ny)
            begin
                $error("normal_y expected %h actual %h", e.ny, word[31:16]);
                errors++;
            end
            if (word[46:32] !== e.nz)
            begin
                $error("normal_z expected %h actual %h", e.nz, word[46:32]);
                errors++;
            end
            if (word[58:47] !== e.col)
            begin
                $error("pixel_col expected %0d actual %0d", e.col, word[58:47]);
                errors++;
            end
            if (word[74:59] !== e.row)
            begin
                $error("pixel_row expected %0d actual %0d", e.row, word[74:59]);
                errors++;
            end
            if (tlast !== e.last)
            begin
                $error("last_in_run expected %0d actual %0d", e.last, tlast);
                errors++;
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [31:0]                  s_tdata;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [d2n_pkg::TDATA_W-1:0]  m_tdata;
    logic                         m_tlast;
    logic                         cfg_we;
    logic [d2n_pkg::CFG_A_W-1:0]  cfg_addr;
    logic [d2n_pkg::CFG_D_W-1:0]  cfg_wdata;

    normal_scoreboard    normals;
    int unsigned         cycle_count = 0;
    int                  burst_left;
    int                  stall_mode = 0;
    int                  random_words;

    depth_to_normal_map_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** depth_to_normal_map_core: FAILED **");
            $finish;
        end
    end

    // Receiver: m_tready follows one of four stall patterns, drawn at random.
    always @(posedge clk)
    begin
        if (cycle_count % 64 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            2:       m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            normals.check_normal(m_tdata, m_tlast);
    end

    task automatic write_reg(logic [d2n_pkg::CFG_A_W-1:0] idx,
                             logic [d2n_pkg::CFG_D_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        normals.set_reg(idx, val);
    endtask

    // Stops sending and waits out the normals in flight.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (normals.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_frame(logic [d2n_pkg::CFG_D_W-1:0] w, logic [d2n_pkg::CFG_D_W-1:0] h);
        wait_drained();
        write_reg(d2n_pkg::CFG_WIDTH, w);
        write_reg(d2n_pkg::CFG_HEIGHT, h);
    endtask

    task automatic send_depth(logic [31:0] sample);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        normals.note_sample(sample);
        burst_left--;
    endtask

    function automatic logic [31:0] random_depth(int mode);
        if (mode == 0)
            return $urandom;
        else if (mode == 1)
            return $urandom_range(0, 262144) - 131072;
        else
            return ($urandom_range(0, 64) - 32) <<< $urandom_range(8, 20);
    endfunction

    // Sends w * h words; a whole frame when w and h are the sizes the block uses.
    task automatic send_frame(int w, int h, int mode);
        for (int i = 0; i < w * h; i++)
            send_depth(random_depth(mode));
    endtask

    initial
    begin
        logic [31:0] corners[9];
        int          w, h;
        normals = new();
        normals.clear();
        burst_left  = 0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = d2n_pkg::CFG_WIDTH;
        cfg_wdata = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme depths on a 3 x 3 frame, so every neighbor case sees them.
        corners = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                    32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF};
        set_frame(3, 3);
        foreach (corners[i]) send_depth(corners[i]);
        // A single pixel frame, and zero sizes that act as one.
        set_frame(1, 1);
        send_depth(32'h0001_0000);
        set_frame(0, 0);
        send_depth(32'h8000_0000);
        set_frame(2, 2);
        send_frame(2, 2, 0);
        set_frame(1, 3);
        send_frame(1, 3, 1);
        set_frame(4, 1);
        send_frame(4, 1, 2);

        // Random frames, mostly small.
        random_words = 0;
        while (random_words < 150)
        begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            set_frame(d2n_pkg::CFG_D_W'(w), d2n_pkg::CFG_D_W'(h));
            send_frame(w, h, $urandom_range(0, 2));
            random_words += w * h;
        end

        // The first rows of the tallest frame, left open at the end of the run.
        set_frame(1, 16'hFFFF);
        send_frame(1, 24, 1);

        wait_drained();
        if (normals.errors == 0)
            $display("** depth_to_normal_map_core: PASSED **");
        else
            $display("** depth_to_normal_map_core: FAILED **");
        $finish;
    end

endmodule
